>>> hw/rtl/hsb2rgb_pkg.sv
// shared types and constants for the hsb to rgb converter
package hsb2rgb_pkg;

    localparam int FRAC_BITS = 16;
    localparam int IN_W      = FRAC_BITS + 1;
    localparam int LVL_W     = 2 * FRAC_BITS + 1;

    localparam logic [IN_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    typedef logic [2:0] t_sector;

    localparam t_sector SEC_R_Y = 3'd0;
    localparam t_sector SEC_Y_G = 3'd1;
    localparam t_sector SEC_G_C = 3'd2;
    localparam t_sector SEC_C_B = 3'd3;
    localparam t_sector SEC_B_M = 3'd4;
    localparam t_sector SEC_M_R = 3'd5;

    typedef struct packed {
        logic [FRAC_BITS-1:0] hue_frac;
        logic [IN_W-1:0]      saturation;
        logic [IN_W-1:0]      brightness;
    } t_hsb_in;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb_out;

endpackage

>>> hw/rtl/hsb2rgb_lvl_byte.sv
// level to 8-bit channel: times 255, round half up, saturate
module hsb2rgb_lvl_byte
    import hsb2rgb_pkg::*;
(
    input  logic [LVL_W-1:0] i_lvl,
    output logic [7:0]       o_byte
);

    localparam int MUL_W = LVL_W + 8;
    localparam int BYTE_W = MUL_W - 2 * FRAC_BITS;
    localparam logic [MUL_W-1:0] HALF_OUT =
        {{(MUL_W-1){1'b0}}, 1'b1} << (2 * FRAC_BITS - 1);

    logic [MUL_W-1:0]  w_mul;
    logic [MUL_W-1:0]  w_sum;
    logic [BYTE_W-1:0] w_byte;

    assign w_mul  = {i_lvl, 8'd0} - {8'd0, i_lvl};
    assign w_sum  = w_mul + HALF_OUT;
    assign w_byte = w_sum[MUL_W-1:2*FRAC_BITS];
    assign o_byte = (w_byte > BYTE_W'(255)) ? 8'hFF : w_byte[7:0];

endmodule

>>> hw/rtl/hsb_to_rgb_pixel_converter_core.sv
// hsb to rgb pixel converter, five-stage pipeline
//
//  channel  valid    stall    payload                    direction
//  hsb in   i_valid  o_stall  i_hsb (t_hsb_in)           into block
//  rgb out  o_valid  i_stall  o_rgb (t_rgb_out)          out of block
//
// one beat per cycle sustained while the output is not stalled
// stages in order: sector/clamp, s*f products, b*level products,
// rounding to bytes, sector select into the output register
// reset clears only the stage valid bits
// each stage holds while the next one is full and stalled, bubbles are squeezed out
module hsb_to_rgb_pixel_converter_core
    import hsb2rgb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_hsb_in  i_hsb,
    output logic     o_valid,
    input  logic     i_stall,
    output t_rgb_out o_rgb
);

    localparam int PROD_W = 2 * IN_W;

    logic r_vld1, r_vld2, r_vld3, r_vld4, r_vld5;
    logic w_en1, w_en2, w_en3, w_en4, w_en5;

    // stage 1
    logic [FRAC_BITS+2:0] w_h6;
    logic [IN_W-1:0]      w_s_clamp;
    logic [IN_W-1:0]      w_b_clamp;
    t_sector              r_sec1;
    logic [FRAC_BITS-1:0] r_f1;
    logic [IN_W-1:0]      r_s1;
    logic [IN_W-1:0]      r_b1;
    logic                 r_grey1;

    // stage 2
    logic [IN_W-1:0]   w_omf;
    logic [PROD_W-1:0] w_sf_prod;
    logic [PROD_W-1:0] w_snf_prod;
    t_sector           r_sec2;
    logic              r_grey2;
    logic [IN_W-1:0]   r_b2;
    logic [IN_W-1:0]   r_oms2;
    logic [IN_W-1:0]   r_sf2;
    logic [IN_W-1:0]   r_snf2;

    // stage 3
    logic [IN_W-1:0]   w_omsf;
    logic [IN_W-1:0]   w_omsnf;
    logic [PROD_W-1:0] w_p_prod;
    logic [PROD_W-1:0] w_q_prod;
    logic [PROD_W-1:0] w_t_prod;
    t_sector           r_sec3;
    logic              r_grey3;
    logic [LVL_W-1:0]  r_lb3;
    logic [LVL_W-1:0]  r_lp3;
    logic [LVL_W-1:0]  r_lq3;
    logic [LVL_W-1:0]  r_lt3;

    // stage 4
    logic [7:0] w_vb, w_vp, w_vq, w_vt;
    t_sector    r_sec4;
    logic       r_grey4;
    logic [7:0] r_vb4, r_vp4, r_vq4, r_vt4;

    // stage 5
    t_rgb_out n_rgb;
    t_rgb_out r_rgb5;

    assign w_en5 = !r_vld5 || !i_stall;
    assign w_en4 = !r_vld4 || w_en5;
    assign w_en3 = !r_vld3 || w_en4;
    assign w_en2 = !r_vld2 || w_en3;
    assign w_en1 = !r_vld1 || w_en2;

    assign o_stall = !w_en1;
    assign o_valid = r_vld5;
    assign o_rgb   = r_rgb5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
            r_vld5 <= 1'b0;
        end else begin
            if (w_en1) r_vld1 <= i_valid;
            if (w_en2) r_vld2 <= r_vld1;
            if (w_en3) r_vld3 <= r_vld2;
            if (w_en4) r_vld4 <= r_vld3;
            if (w_en5) r_vld5 <= r_vld4;
        end
    end

    // hue times six, clamp to one
    assign w_h6 = {1'b0, i_hsb.hue_frac, 2'b00} + {2'b00, i_hsb.hue_frac, 1'b0};
    assign w_s_clamp = (i_hsb.saturation > ONE) ? ONE : i_hsb.saturation;
    assign w_b_clamp = (i_hsb.brightness > ONE) ? ONE : i_hsb.brightness;

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_sec1  <= w_h6[FRAC_BITS+2:FRAC_BITS];
            r_f1    <= w_h6[FRAC_BITS-1:0];
            r_s1    <= w_s_clamp;
            r_b1    <= w_b_clamp;
            r_grey1 <= (w_s_clamp == '0);
        end
    end

    // s*f and s*(1-f)
    assign w_omf      = ONE - {1'b0, r_f1};
    assign w_sf_prod  = r_s1 * {1'b0, r_f1};
    assign w_snf_prod = r_s1 * w_omf;

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_sec2  <= r_sec1;
            r_grey2 <= r_grey1;
            r_b2    <= r_b1;
            r_oms2  <= ONE - r_s1;
            r_sf2   <= w_sf_prod[2*FRAC_BITS:FRAC_BITS];
            r_snf2  <= w_snf_prod[2*FRAC_BITS:FRAC_BITS];
        end
    end

    // p, q, t levels
    assign w_omsf   = ONE - r_sf2;
    assign w_omsnf  = ONE - r_snf2;
    assign w_p_prod = r_b2 * r_oms2;
    assign w_q_prod = r_b2 * w_omsf;
    assign w_t_prod = r_b2 * w_omsnf;

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_sec3  <= r_sec2;
            r_grey3 <= r_grey2;
            r_lb3   <= {r_b2, {FRAC_BITS{1'b0}}};
            r_lp3   <= w_p_prod[LVL_W-1:0];
            r_lq3   <= w_q_prod[LVL_W-1:0];
            r_lt3   <= w_t_prod[LVL_W-1:0];
        end
    end

    hsb2rgb_lvl_byte u_conv_b (.i_lvl(r_lb3), .o_byte(w_vb));
    hsb2rgb_lvl_byte u_conv_p (.i_lvl(r_lp3), .o_byte(w_vp));
    hsb2rgb_lvl_byte u_conv_q (.i_lvl(r_lq3), .o_byte(w_vq));
    hsb2rgb_lvl_byte u_conv_t (.i_lvl(r_lt3), .o_byte(w_vt));

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r_sec4  <= r_sec3;
            r_grey4 <= r_grey3;
            r_vb4   <= w_vb;
            r_vp4   <= w_vp;
            r_vq4   <= w_vq;
            r_vt4   <= w_vt;
        end
    end

    // sector select
    always_comb begin
        if (r_grey4) begin
            n_rgb = '{red: r_vb4, green: r_vb4, blue: r_vb4};
        end else begin
            case (r_sec4)
                SEC_R_Y: n_rgb = '{red: r_vb4, green: r_vt4, blue: r_vp4};
                SEC_Y_G: n_rgb = '{red: r_vq4, green: r_vb4, blue: r_vp4};
                SEC_G_C: n_rgb = '{red: r_vp4, green: r_vb4, blue: r_vt4};
                SEC_C_B: n_rgb = '{red: r_vp4, green: r_vq4, blue: r_vb4};
                SEC_B_M: n_rgb = '{red: r_vt4, green: r_vp4, blue: r_vb4};
                SEC_M_R: n_rgb = '{red: r_vb4, green: r_vp4, blue: r_vq4};
                default: n_rgb = '{red: r_vb4, green: r_vp4, blue: r_vq4};
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en5) begin
            r_rgb5 <= n_rgb;
        end
    end

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_vld1 && r_vld2 && r_vld3 && r_vld4 && r_vld5))
        else $error("input stalled with a free stage");

    a_sector_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld1 |-> (r_sec1 <= SEC_M_R))
        else $error("hue sector out of range");

    a_bright_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld4 |-> (r_vb4 >= r_vp4 && r_vb4 >= r_vq4 && r_vb4 >= r_vt4))
        else $error("brightness byte below a derived level");

    a_grey_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld4 && r_grey4 && w_en5) |=>
            (o_rgb.red == o_rgb.green && o_rgb.green == o_rgb.blue))
        else $error("grey beat with unequal channels");

    a_out_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld4 && w_en5) |=> o_valid)
        else $error("beat lost between last two stages");

endmodule
